FILE: design/playfair_digram_cipher_assert.svh
// Assertion macros for the digram cipher checker.
`ifndef PLAYFAIR_DIGRAM_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAM_CIPHER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define PFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfc checker: property failed");

// Next-cycle implication, off during reset.
`define PFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfc checker: property failed");

`endif

FILE: design/pfc_pkg.sv
package pfc_pkg;

  localparam int LETTER_COUNT = 26;
  localparam int SIDE         = 5;
  localparam int CELLS        = SIDE * SIDE;

  typedef logic [4:0] letter_t;
  typedef logic [2:0] func_t;

  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_Z = 5'd25;

  localparam func_t FUNC_CLEAR  = 3'd0;
  localparam func_t FUNC_KEY    = 3'd1;
  localparam func_t FUNC_FINISH = 3'd2;
  localparam func_t FUNC_ENC    = 3'd3;
  localparam func_t FUNC_DEC    = 3'd4;

  typedef struct packed {
    func_t   func;
    letter_t letter_a;
    letter_t letter_b;
  } in_beat_t;

  typedef struct packed {
    letter_t out_a;
    letter_t out_b;
    logic    status;
  } out_beat_t;

  // Square coordinate, row and column each 0..4.
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } cell_t;

  // Saturate to z, then read j as i.
  function automatic letter_t fold_letter(letter_t v);
    letter_t s;
    s = (v > LETTER_Z) ? LETTER_Z : v;
    return (s == LETTER_J) ? LETTER_I : s;
  endfunction

  // Linear cell index 0..24 to row/column.
  function automatic cell_t cell_of(letter_t idx);
    cell_t   c;
    letter_t base;
    if (idx >= 5'd20) begin
      c.row = 3'd4;
      base  = 5'd20;
    end else if (idx >= 5'd15) begin
      c.row = 3'd3;
      base  = 5'd15;
    end else if (idx >= 5'd10) begin
      c.row = 3'd2;
      base  = 5'd10;
    end else if (idx >= 5'd5) begin
      c.row = 3'd1;
      base  = 5'd5;
    end else begin
      c.row = 3'd0;
      base  = 5'd0;
    end
    c.col = 3'(idx - base);
    return c;
  endfunction

  function automatic letter_t index_of(cell_t c);
    letter_t r5;
    r5 = {2'b00, c.row};
    return (r5 << 2) + r5 + {2'b00, c.col};
  endfunction

  // One step along a row or column, wrapping at the edge.
  function automatic logic [2:0] step_mod(logic [2:0] v, logic fwd);
    if (fwd) begin
      return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    end
    return (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
  endfunction

endpackage

FILE: design/playfair_digram_cipher.sv
// channel  | direction | payload     | handshake
// ---------+-----------+-------------+--------------------
// in_      | input     | in_beat_t   | in_valid / in_stall
// out_     | output    | out_beat_t  | out_valid / out_stall
//
// One item at a time: a digram on a finished square does a position memory
// read, then a square memory read; finish walks the 26 letters, one per cycle,
// placing the unused ones through the square write port.
// rst_n is synchronous; the key square and position memories hold no reset,
// they are fully rewritten by key and finish before any digram may read them.
// A stalled result sits in the output register while the next beat is taken.
module playfair_digram_cipher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pfc_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pfc_pkg::out_beat_t  out_data
);
  import pfc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOK   = 3'd1;
  localparam logic [2:0] ST_FETCH  = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  localparam logic [LETTER_COUNT-1:0] USED_RESET = LETTER_COUNT'(1) << LETTER_J;

  logic [2:0]              state_r, state_nxt;
  logic [LETTER_COUNT-1:0] used_r, used_nxt;
  letter_t                 fill_r, fill_nxt;
  logic                    ready_r, ready_nxt;
  letter_t                 walk_r, walk_nxt;
  logic                    fwd_r, fwd_nxt;
  out_beat_t               res_r, res_nxt;
  logic                    out_valid_r;
  out_beat_t               out_data_r;

  // letter -> cell, cell index -> letter
  cell_t   pos_mem [LETTER_COUNT];
  letter_t sq_mem  [CELLS];

  logic    place_en;
  letter_t place_ltr;
  letter_t pos_raddr_a, pos_raddr_b;
  cell_t   pos_rd_a, pos_rd_b;
  letter_t sq_raddr_a, sq_raddr_b;
  letter_t sq_rd_a, sq_rd_b;
  logic    sq_we;
  cell_t   na, nb;
  logic    out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign sq_we     = place_en && (fill_r < letter_t'(CELLS));

  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    fill_nxt    = fill_r;
    ready_nxt   = ready_r;
    walk_nxt    = walk_r;
    fwd_nxt     = fwd_r;
    res_nxt     = res_r;
    place_en    = 1'b0;
    place_ltr   = in_data.letter_a;
    pos_raddr_a = fold_letter(in_data.letter_a);
    pos_raddr_b = fold_letter(in_data.letter_b);
    na          = '0;
    nb          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          state_nxt = ST_EMIT;
          case (in_data.func) inside
            FUNC_CLEAR: begin
              used_nxt  = USED_RESET;
              fill_nxt  = '0;
              ready_nxt = 1'b0;
            end
            FUNC_KEY: begin
              if (!ready_r && in_data.letter_a < letter_t'(LETTER_COUNT) &&
                  !used_r[in_data.letter_a]) begin
                place_en = 1'b1;
              end
            end
            FUNC_FINISH: begin
              if (!ready_r) begin
                walk_nxt  = '0;
                state_nxt = ST_FINISH;
              end
            end
            FUNC_ENC, FUNC_DEC: begin
              if (!ready_r) begin
                res_nxt.status = 1'b1;
              end else begin
                fwd_nxt   = (in_data.func == FUNC_ENC);
                state_nxt = ST_LOOK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        if (pos_rd_a.row == pos_rd_b.row) begin
          na = '{row: pos_rd_a.row, col: step_mod(pos_rd_a.col, fwd_r)};
          nb = '{row: pos_rd_b.row, col: step_mod(pos_rd_b.col, fwd_r)};
        end else if (pos_rd_a.col == pos_rd_b.col) begin
          na = '{row: step_mod(pos_rd_a.row, fwd_r), col: pos_rd_a.col};
          nb = '{row: step_mod(pos_rd_b.row, fwd_r), col: pos_rd_b.col};
        end else begin
          na = '{row: pos_rd_a.row, col: pos_rd_b.col};
          nb = '{row: pos_rd_b.row, col: pos_rd_a.col};
        end
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        res_nxt.out_a = sq_rd_a;
        res_nxt.out_b = sq_rd_b;
        state_nxt     = ST_EMIT;
      end
      ST_FINISH: begin
        place_ltr = walk_r;
        place_en  = !used_r[walk_r];
        if (walk_r == letter_t'(LETTER_COUNT - 1)) begin
          ready_nxt = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          walk_nxt = walk_r + 5'd1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (place_en) begin
      used_nxt = used_nxt | (LETTER_COUNT'(1) << place_ltr);
      if (sq_we) begin
        fill_nxt = fill_r + 5'd1;
      end
    end
  end

  assign sq_raddr_a = index_of(na);
  assign sq_raddr_b = index_of(nb);

  // All writes finish before ready is set, so digram reads never meet a
  // write in flight and need no forwarding.
  always_ff @(posedge clk) begin
    if (sq_we) begin
      sq_mem[fill_r]     <= place_ltr;
      pos_mem[place_ltr] <= cell_of(fill_r);
    end
    pos_rd_a <= pos_mem[pos_raddr_a];
    pos_rd_b <= pos_mem[pos_raddr_b];
    sq_rd_a  <= sq_mem[sq_raddr_a];
    sq_rd_b  <= sq_mem[sq_raddr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= USED_RESET;
      fill_r  <= '0;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      fill_r  <= fill_nxt;
      ready_r <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r <= walk_nxt;
    fwd_r  <= fwd_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_data_r <= res_r;
    end
  end

endmodule

FILE: design/pfc_checker.sv
`include "playfair_digram_cipher_assert.svh"

module pfc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input pfc_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input pfc_pkg::out_beat_t out_data
);
  import pfc_pkg::*;

  // held result beat stays put
  `PFC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // one item at a time: busy right after a beat is taken
  `PFC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // refused digram carries no letters
  `PFC_ASSERT_NOW(a_refused_zero, out_valid && out_data.status,
                  out_data.out_a == '0 && out_data.out_b == '0)

  // j is never in the square, so never comes out
  `PFC_ASSERT_NOW(a_no_j, out_valid,
                  out_data.out_a != LETTER_J && out_data.out_b != LETTER_J &&
                  out_data.out_a <= LETTER_Z && out_data.out_b <= LETTER_Z)

endmodule

bind playfair_digram_cipher pfc_checker u_pfc_checker (.*);

FILE: tb/sv/playfair_digram_cipher_tb.sv
module playfair_digram_cipher_tb;
  import pfc_pkg::*;

  // Codes outside the defined set; the block answers them with all zeros.
  localparam func_t FUNC_SPARE_LO = 3'd5;
  localparam func_t FUNC_SPARE_HI = 3'd7;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_t;

  class cipher_board;
    letter_t     grid[CELLS];
    bit [25:0]   taken;
    int unsigned fill;
    bit          ready;
    out_beat_t   pending_cipher_out[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      foreach (grid[k]) grid[k] = '0;
      taken = '0;
      taken[LETTER_J] = 1'b1;
      fill = 0;
      ready = 1'b0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void place(letter_t l);
      if (fill < CELLS) begin
        grid[fill] = l;
        fill++;
      end
      taken[l] = 1'b1;
    endfunction

    // Out-of-range letters clamp to z, then j reads as i.
    function letter_t fold(letter_t v);
      letter_t s;
      s = v;
      if (s > LETTER_Z) s = LETTER_Z;
      if (s == LETTER_J) s = LETTER_I;
      return s;
    endfunction

    function int unsigned find_cell(letter_t l);
      for (int k = 0; k < CELLS; k++) begin
        if (grid[k] == l) return k;
      end
      return 0;
    endfunction

    function void note_input(in_beat_t b);
      out_beat_t   r;
      int unsigned pa, pb, ra, ca, rb, cb, na, nb, step;
      r = '0;
      case (b.func)
        FUNC_CLEAR: begin
          taken = '0;
          taken[LETTER_J] = 1'b1;
          fill = 0;
          ready = 1'b0;
        end
        FUNC_KEY: begin
          if (!ready && b.letter_a < LETTER_COUNT && !taken[b.letter_a]) place(b.letter_a);
        end
        FUNC_FINISH: begin
          if (!ready) begin
            for (int c = 0; c < LETTER_COUNT; c++) begin
              if (!taken[c]) place(letter_t'(c));
            end
            ready = 1'b1;
          end
        end
        FUNC_ENC, FUNC_DEC: begin
          if (!ready) begin
            r.status = 1'b1;
          end else begin
            step = (b.func == FUNC_ENC) ? 1 : SIDE - 1;
            pa = find_cell(fold(b.letter_a));
            pb = find_cell(fold(b.letter_b));
            ra = pa / SIDE;
            ca = pa % SIDE;
            rb = pb / SIDE;
            cb = pb % SIDE;
            if (ra == rb) begin
              na = ra * SIDE + (ca + step) % SIDE;
              nb = rb * SIDE + (cb + step) % SIDE;
            end else if (ca == cb) begin
              na = ((ra + step) % SIDE) * SIDE + ca;
              nb = ((rb + step) % SIDE) * SIDE + cb;
            end else begin
              na = ra * SIDE + cb;
              nb = rb * SIDE + ca;
            end
            r.out_a = grid[na];
            r.out_b = grid[nb];
          end
        end
        default: ;
      endcase
      pending_cipher_out.push_back(r);
    endfunction

    task report(string msg);
      $display("%0t: result %0d: %s", $time, results_seen, msg);
      mismatches++;
    endtask

    task check_result(out_beat_t got);
      out_beat_t want;
      if (pending_cipher_out.size() == 0) begin
        report($sformatf("unexpected beat %h", got));
      end else begin
        want = pending_cipher_out.pop_front();
        if (got.out_a !== want.out_a)
          report($sformatf("out_a got %0d want %0d", got.out_a, want.out_a));
        if (got.out_b !== want.out_b)
          report($sformatf("out_b got %0d want %0d", got.out_b, want.out_b));
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
      end
      results_seen++;
    endtask

    function int pending();
      return pending_cipher_out.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;

  cipher_board board;
  int          burst_left = 12;
  int unsigned items_sent = 0;
  stall_kind_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  playfair_digram_cipher uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic in_beat_t beat_of(func_t f, letter_t a, letter_t b);
    in_beat_t x;
    x.func = f;
    x.letter_a = a;
    x.letter_b = b;
    return x;
  endfunction

  // Mostly real letters, now and then a code above z.
  function automatic letter_t pick_letter();
    if ($urandom_range(0, 7) == 0) return letter_t'($urandom_range(26, 31));
    return letter_t'($urandom_range(0, 25));
  endfunction

  function automatic func_t pick_digram();
    return ($urandom_range(0, 1) == 1) ? FUNC_ENC : FUNC_DEC;
  endfunction

  // Called at a rising edge; returns at the edge that takes the beat, or
  // after the gap that closes a burst.
  task automatic send(in_beat_t b);
    int gap;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    board.note_input(b);
    if (b.func <= FUNC_DEC) items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    if (stall_left == 0) begin
      stall_mode = stall_kind_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= ((stall_left % 7) < 3);
    endcase
  end

  initial begin
    int nk;
    int nd;
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Digrams before any key square exists are refused.
    send(beat_of(FUNC_ENC, 5'd0, 5'd1));
    send(beat_of(FUNC_DEC, 5'd31, 5'd31));
    // Key letters p l a y f a z with junk mixed in: above-z codes, j, a repeat.
    send(beat_of(FUNC_KEY, 5'd31, 5'd31));
    send(beat_of(FUNC_KEY, LETTER_J, 5'd0));
    send(beat_of(FUNC_KEY, 5'd15, 5'd0));
    send(beat_of(FUNC_KEY, 5'd11, 5'd0));
    send(beat_of(FUNC_KEY, 5'd0, 5'd0));
    send(beat_of(FUNC_KEY, 5'd24, 5'd0));
    send(beat_of(FUNC_KEY, 5'd5, 5'd0));
    send(beat_of(FUNC_KEY, 5'd0, 5'd0));
    send(beat_of(FUNC_KEY, LETTER_Z, 5'd0));
    send(beat_of(FUNC_KEY, 5'd26, 5'd0));
    send(beat_of(FUNC_FINISH, 5'd0, 5'd0));
    send(beat_of(FUNC_FINISH, 5'd0, 5'd0));
    // Late key letter must leave the square alone.
    send(beat_of(FUNC_KEY, 5'd1, 5'd0));
    // Square: p l a y f / z b c d e / g h i k m / n o q r s / t u v w x
    send(beat_of(FUNC_ENC, 5'd15, 5'd0));
    send(beat_of(FUNC_DEC, 5'd11, 5'd5));
    send(beat_of(FUNC_ENC, 5'd15, LETTER_Z));
    send(beat_of(FUNC_DEC, 5'd19, 5'd15));
    send(beat_of(FUNC_ENC, 5'd7, 5'd4));
    send(beat_of(FUNC_DEC, LETTER_J, LETTER_I));
    send(beat_of(FUNC_ENC, 5'd31, 5'd0));
    send(beat_of(FUNC_SPARE_LO, 5'd31, 5'd31));
    send(beat_of(FUNC_SPARE_HI, 5'd31, 5'd31));
    send(beat_of(FUNC_CLEAR, 5'd0, 5'd0));
    send(beat_of(FUNC_DEC, 5'd2, 5'd3));

    while (items_sent < 1550) begin
      if ($urandom_range(0, 99) < 8) begin
        send(beat_of(func_t'($urandom_range(0, 7)), letter_t'($urandom_range(0, 31)),
                     letter_t'($urandom_range(0, 31))));
      end else begin
        send(beat_of(FUNC_CLEAR, pick_letter(), pick_letter()));
        nk = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 12);
        for (int k = 0; k < nk; k++) begin
          send(beat_of(FUNC_KEY, pick_letter(), pick_letter()));
          if ($urandom_range(0, 15) == 0)
            send(beat_of(pick_digram(), pick_letter(), pick_letter()));
        end
        // Now and then the square is left unfinished.
        if ($urandom_range(0, 9) != 0)
          send(beat_of(FUNC_FINISH, pick_letter(), pick_letter()));
        nd = $urandom_range(5, 40);
        for (int k = 0; k < nd; k++) begin
          if ($urandom_range(0, 19) == 0)
            send(beat_of(($urandom_range(0, 1) == 1) ? FUNC_KEY : FUNC_FINISH,
                         pick_letter(), pick_letter()));
          else
            send(beat_of(pick_digram(), pick_letter(), pick_letter()));
        end
      end
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
